/* sv/two_wheel_bang_bang_speed_control_macros.svh */
// Assertion macros shared by the speed controller modules.
`ifndef TWO_WHEEL_BANG_BANG_SPEED_CONTROL_MACROS_SVH
`define TWO_WHEEL_BANG_BANG_SPEED_CONTROL_MACROS_SVH

// Checks an implication on every rising edge of clk outside reset.
`define TWS_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks an invariant on every rising edge of clk outside reset.
`define TWS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

/* sv/tws_pkg.sv */
package tws_pkg;

    localparam int TIMEOUT_TICKS = 31250;
    localparam logic [15:0] IDLE_EDGES = 16'hFFFF;

    localparam logic [14:0] FAST_TARGET_RESET = 15'd100;
    localparam logic [14:0] SLOW_TARGET_RESET = 15'd200;
    localparam logic [15:0] SHORT_LIMIT_RESET = 16'd20;

    typedef enum logic [1:0] {
        DRV_STOP  = 2'd0,
        DRV_FWD   = 2'd1,
        DRV_REV   = 2'd2,
        DRV_BRAKE = 2'd3
    } drive_t;

    typedef enum logic [2:0] {
        FN_TICK  = 3'd0,
        FN_LEDGE = 3'd1,
        FN_REDGE = 3'd2,
        FN_CTRL  = 3'd3,
        FN_WALK  = 3'd4,
        FN_MOVE  = 3'd5,
        FN_TURN  = 3'd6,
        FN_RESET = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        CFG_FAST  = 2'd0,
        CFG_SLOW  = 2'd1,
        CFG_LIMIT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic        tick;
        logic        edge_hit;
        logic        control;
        logic        walk;
        logic        start;
        logic        rst;
        logic [15:0] walk_period;
        drive_t      walk_dir;
        drive_t      start_dir;
        logic [15:0] start_target;
    } wheel_cmd_t;

endpackage

/* sv/tws_wheel.sv */
`include "two_wheel_bang_bang_speed_control_macros.svh"

module tws_wheel
    import tws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  wheel_cmd_t  cmd,
    output drive_t      drive,
    output logic [14:0] period
);

    localparam logic [14:0] TMO = 15'(TIMEOUT_TICKS);

    logic [14:0] tick_reg, tick_next;
    logic [14:0] avg_reg, avg_next;
    logic [14:0] prev_reg, prev_next;
    logic [15:0] target_reg, target_next;
    drive_t      heading_reg, heading_next;
    drive_t      drive_reg, drive_next;
    logic [15:0] pair_sum;

    assign pair_sum = {1'b0, tick_reg} + {1'b0, prev_reg};

    always_comb
    begin
        tick_next    = tick_reg;
        avg_next     = avg_reg;
        prev_next    = prev_reg;
        target_next  = target_reg;
        heading_next = heading_reg;
        drive_next   = drive_reg;
        if (cmd.rst)
        begin
            drive_next  = DRV_BRAKE;
            tick_next   = '0;
            target_next = {1'b0, TMO};
            avg_next    = TMO;
            prev_next   = TMO;
        end
        else if (cmd.tick)
        begin
            if (tick_reg < TMO)
            begin
                tick_next = tick_reg + 15'd1;
            end
            else
            begin
                avg_next = TMO;
            end
        end
        else if (cmd.edge_hit)
        begin
            tick_next = '0;
            if (tick_reg > TMO)
            begin
                avg_next = TMO;
            end
            else
            begin
                avg_next  = pair_sum[15:1];
                prev_next = tick_reg;
            end
        end
        else if (cmd.control)
        begin
            if (target_reg == {1'b0, TMO})
            begin
                drive_next = DRV_BRAKE;
            end
            else if ({1'b0, avg_reg} > target_reg)
            begin
                drive_next = (heading_reg == DRV_FWD) ? DRV_FWD : DRV_REV;
            end
            else
            begin
                drive_next = DRV_STOP;
            end
        end
        else if (cmd.walk)
        begin
            target_next  = (cmd.walk_dir == DRV_FWD || cmd.walk_dir == DRV_REV)
                           ? cmd.walk_period : {1'b0, TMO};
            heading_next = cmd.walk_dir;
            tick_next    = '0;
            drive_next   = cmd.walk_dir;
        end
        else if (cmd.start)
        begin
            target_next  = cmd.start_target;
            heading_next = cmd.start_dir;
            if (tick_reg == TMO)
            begin
                tick_next = '0;
            end
            drive_next   = cmd.start_dir;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            avg_reg     <= TMO;
            prev_reg    <= TMO;
            target_reg  <= {1'b0, TMO};
            heading_reg <= DRV_STOP;
            drive_reg   <= DRV_BRAKE;
        end
        else
        begin
            tick_reg    <= tick_next;
            avg_reg     <= avg_next;
            prev_reg    <= prev_next;
            target_reg  <= target_next;
            heading_reg <= heading_next;
            drive_reg   <= drive_next;
        end
    end

    assign drive  = drive_reg;
    assign period = avg_reg;

    `TWS_ASSERT_ALWAYS(tick_in_range, tick_reg <= TMO, "Tick counter passed the timeout.")
    `TWS_ASSERT_IMPL(brake_on_rst, cmd.rst, ##1 (drive_reg == DRV_BRAKE && tick_reg == 15'd0), "Motion reset did not brake the wheel.")

endmodule

/* sv/tws_cmd.sv */
`include "two_wheel_bang_bang_speed_control_macros.svh"

module tws_cmd
    import tws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  func_t       func,
    input  logic        sensor_high,
    input  logic        wheel_sel,
    input  logic [15:0] walk_period,
    input  drive_t      walk_dir,
    input  logic [15:0] travel,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output wheel_cmd_t  left_cmd,
    output wheel_cmd_t  right_cmd,
    output logic        busy
);

    logic [14:0] fast_reg;
    logic [14:0] slow_reg;
    logic [15:0] limit_reg;
    logic [15:0] edges_reg, edges_next;

    logic        is_move, is_turn, neg, travel_zero, right_edge, count_done;
    logic [15:0] mag, edges_dec, tgt;
    drive_t      left_dir, right_dir;
    wheel_cmd_t  base_cmd;

    always_comb
    begin
        is_move     = (func == FN_MOVE) || (func == FN_TURN);
        is_turn     = (func == FN_TURN);
        neg         = travel[15];
        travel_zero = (travel == 16'd0);
        mag         = neg ? (16'd0 - travel) : travel;
        left_dir    = neg ? DRV_REV : DRV_FWD;
        if (is_turn)
        begin
            right_dir = neg ? DRV_FWD : DRV_REV;
        end
        else
        begin
            right_dir = left_dir;
        end
        tgt        = (mag > limit_reg) ? {1'b0, fast_reg} : {1'b0, slow_reg};
        right_edge = (func == FN_REDGE) && sensor_high;
        edges_dec  = edges_reg - 16'd1;
        count_done = right_edge && (edges_reg != IDLE_EDGES) && (edges_dec == 16'd0);

        base_cmd              = '0;
        base_cmd.tick         = fire && (func == FN_TICK);
        base_cmd.control      = fire && (func == FN_CTRL);
        base_cmd.start        = fire && is_move && !travel_zero;
        base_cmd.rst          = fire && ((func == FN_RESET) || (is_move && travel_zero)
                                         || count_done);
        base_cmd.walk_period  = walk_period;
        base_cmd.walk_dir     = walk_dir;
        base_cmd.start_target = tgt;

        left_cmd           = base_cmd;
        left_cmd.edge_hit  = fire && (func == FN_LEDGE) && sensor_high;
        left_cmd.walk      = fire && (func == FN_WALK) && !wheel_sel;
        left_cmd.start_dir = left_dir;

        right_cmd           = base_cmd;
        right_cmd.edge_hit  = fire && right_edge;
        right_cmd.walk      = fire && (func == FN_WALK) && wheel_sel;
        right_cmd.start_dir = right_dir;

        edges_next = edges_reg;
        if (fire)
        begin
            unique case (func) inside
                FN_REDGE:
                begin
                    if (right_edge && edges_reg != IDLE_EDGES)
                    begin
                        edges_next = count_done ? IDLE_EDGES : edges_dec;
                    end
                end
                FN_WALK, FN_RESET:
                begin
                    edges_next = IDLE_EDGES;
                end
                FN_MOVE, FN_TURN:
                begin
                    edges_next = travel_zero ? IDLE_EDGES : mag;
                end
                default:
                begin
                    edges_next = edges_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_reg <= IDLE_EDGES;
            fast_reg  <= FAST_TARGET_RESET;
            slow_reg  <= SLOW_TARGET_RESET;
            limit_reg <= SHORT_LIMIT_RESET;
        end
        else
        begin
            edges_reg <= edges_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_FAST:  fast_reg  <= cfg_data[14:0];
                    CFG_SLOW:  slow_reg  <= cfg_data[14:0];
                    CFG_LIMIT: limit_reg <= cfg_data;
                    default:   limit_reg <= limit_reg;
                endcase
            end
        end
    end

    assign busy = (edges_reg != IDLE_EDGES);

    `TWS_ASSERT_ALWAYS(count_nonzero, edges_reg != 16'd0, "Edge countdown rests at zero.")
    `TWS_ASSERT_IMPL(one_wheel_walk, fire, !(left_cmd.walk && right_cmd.walk),
        "Walk went to both wheels.")

endmodule

/* sv/two_wheel_bang_bang_speed_control.sv */
// Two-wheel bang-bang speed controller. Each request on the command channel (count tick,
// hall edge, control tick, walk, move, turn or reset) produces exactly one result carrying
// both drive codes, the busy flag of a counted move and both averaged wheel periods as they
// stand after the request. A request is registered on acceptance and applied to the wheel
// state once the result register is free or being read, so one request can be taken every
// cycle unless a held result blocks it, and its result is registered as it is applied; a
// held result stalls the channel only if the input register is also full. Configuration
// writes are always accepted and must only be issued while idle.
`include "two_wheel_bang_bang_speed_control_macros.svh"

module two_wheel_bang_bang_speed_control
    import tws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  func,
    input  logic        sensor_high,
    input  logic        wheel_sel,
    input  logic [15:0] walk_period,
    input  logic [1:0]  walk_dir,
    input  logic signed [15:0] travel,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  left_drive,
    output logic [1:0]  right_drive,
    output logic        busy_res,
    output logic [14:0] left_period,
    output logic [14:0] right_period,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        s1_valid_reg;
    func_t       s1_func_reg;
    logic        s1_high_reg;
    logic        s1_wsel_reg;
    logic [15:0] s1_wper_reg;
    drive_t      s1_wdir_reg;
    logic [15:0] s1_travel_reg;
    logic        res_valid_reg;

    logic        advance;
    logic        fire;
    wheel_cmd_t  left_cmd, right_cmd;
    drive_t      left_drv, right_drv;
    logic        busy;

    assign advance   = !res_valid_reg || res_ready;
    assign fire      = s1_valid_reg && advance;
    assign cmd_ready = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_func_reg   <= func_t'(func);
            s1_high_reg   <= sensor_high;
            s1_wsel_reg   <= wheel_sel;
            s1_wper_reg   <= walk_period;
            s1_wdir_reg   <= drive_t'(walk_dir);
            s1_travel_reg <= travel;
        end
    end

    tws_cmd u_cmd (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .func        (s1_func_reg),
        .sensor_high (s1_high_reg),
        .wheel_sel   (s1_wsel_reg),
        .walk_period (s1_wper_reg),
        .walk_dir    (s1_wdir_reg),
        .travel      (s1_travel_reg),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_cmd    (left_cmd),
        .right_cmd   (right_cmd),
        .busy        (busy)
    );

    tws_wheel u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (left_cmd),
        .drive  (left_drv),
        .period (left_period)
    );

    tws_wheel u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (right_cmd),
        .drive  (right_drv),
        .period (right_period)
    );

    assign res_valid   = res_valid_reg;
    assign left_drive  = left_drv;
    assign right_drive = right_drv;
    assign busy_res    = busy;

    `TWS_ASSERT_IMPL(res_from_stage, $rose(res_valid_reg), $past(s1_valid_reg),
        "Result appeared without a registered request.")
    `TWS_ASSERT_IMPL(state_held_on_stall, !fire,
        ##1 ($stable(left_drv) && $stable(right_drv) && $stable(busy)),
        "Wheel state moved without a request.")

endmodule

/* tb/two_wheel_bang_bang_speed_control_test.sv */
`timescale 1ns / 1ps

module two_wheel_bang_bang_speed_control_test;
    import tws_pkg::*;

    localparam int CYCLE_LIMIT = 40000;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        func_t              fn;
        logic               sensor;
        logic               wheel;
        logic [15:0]        period;
        logic [1:0]         dir;
        logic signed [15:0] travel;
    } wheel_request_t;

    typedef struct {
        drive_t      left_drv;
        drive_t      right_drv;
        logic        busy;
        logic [14:0] left_per;
        logic [14:0] right_per;
    } wheel_status_t;

    class wheel_state_tracker;
        logic [14:0]   fast_target;
        logic [14:0]   slow_target;
        logic [15:0]   move_limit;
        logic [14:0]   tick_cnt [2];
        logic [14:0]   avg_per [2];
        logic [14:0]   prev_per [2];
        logic [15:0]   target_per [2];
        drive_t        heading [2];
        drive_t        drive [2];
        logic [15:0]   edges_to_go;
        wheel_status_t expected_status [$];
        int            fail_count;

        function new();
            fast_target = FAST_TARGET_RESET;
            slow_target = SLOW_TARGET_RESET;
            move_limit = SHORT_LIMIT_RESET;
            heading[0] = DRV_STOP;
            heading[1] = DRV_STOP;
            fail_count = 0;
            stop_motion();
        endfunction

        function void stop_motion();
            for (int w = 0; w < 2; w++)
            begin
                drive[w] = DRV_BRAKE;
                tick_cnt[w] = '0;
                target_per[w] = 16'(TIMEOUT_TICKS);
                avg_per[w] = 15'(TIMEOUT_TICKS);
                prev_per[w] = 15'(TIMEOUT_TICKS);
            end
            edges_to_go = IDLE_EDGES;
        endfunction

        function void hall_edge(int w);
            logic [14:0] d;
            logic [15:0] sum;
            d = tick_cnt[w];
            tick_cnt[w] = '0;
            if (d > TIMEOUT_TICKS)
            begin
                avg_per[w] = 15'(TIMEOUT_TICKS);
            end
            else
            begin
                sum = {1'b0, d} + {1'b0, prev_per[w]};
                avg_per[w] = sum[15:1];
                prev_per[w] = d;
            end
        endfunction

        function void control_wheel(int w);
            if (target_per[w] == TIMEOUT_TICKS)
                drive[w] = DRV_BRAKE;
            else if ({1'b0, avg_per[w]} > target_per[w])
                drive[w] = (heading[w] == DRV_FWD) ? DRV_FWD : DRV_REV;
            else
                drive[w] = DRV_STOP;
        endfunction

        function void start_counted(logic signed [15:0] travel, bit turn);
            logic [15:0] mag;
            logic [15:0] tgt;
            drive_t      dl;
            drive_t      dr;
            if (travel == 0)
            begin
                stop_motion();
                return;
            end
            if (travel[15])
            begin
                mag = -travel;
                dl = DRV_REV;
                dr = turn ? DRV_FWD : DRV_REV;
            end
            else
            begin
                mag = travel;
                dl = DRV_FWD;
                dr = turn ? DRV_REV : DRV_FWD;
            end
            edges_to_go = mag;
            tgt = (mag > move_limit) ? {1'b0, fast_target} : {1'b0, slow_target};
            target_per[0] = tgt;
            target_per[1] = tgt;
            heading[0] = dl;
            heading[1] = dr;
            for (int w = 0; w < 2; w++)
                if (tick_cnt[w] == TIMEOUT_TICKS)
                    tick_cnt[w] = '0;
            drive[0] = dl;
            drive[1] = dr;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] data);
            case (idx)
                CFG_FAST:  fast_target = data[14:0];
                CFG_SLOW:  slow_target = data[14:0];
                CFG_LIMIT: move_limit = data;
                default:   ;
            endcase
        endfunction

        function void note_request(wheel_request_t r);
            wheel_status_t s;
            int            w;
            w = r.wheel;
            case (r.fn)
                FN_TICK:
                    for (int i = 0; i < 2; i++)
                    begin
                        if (tick_cnt[i] < TIMEOUT_TICKS)
                            tick_cnt[i] = tick_cnt[i] + 1'b1;
                        else
                            avg_per[i] = 15'(TIMEOUT_TICKS);
                    end
                FN_LEDGE:
                    if (r.sensor)
                        hall_edge(0);
                FN_REDGE:
                    if (r.sensor)
                    begin
                        hall_edge(1);
                        if (edges_to_go != IDLE_EDGES)
                        begin
                            edges_to_go = edges_to_go - 1'b1;
                            if (edges_to_go == 0)
                                stop_motion();
                        end
                    end
                FN_CTRL:
                begin
                    control_wheel(0);
                    control_wheel(1);
                end
                FN_WALK:
                begin
                    target_per[w] = (r.dir == DRV_FWD || r.dir == DRV_REV) ?
                                    r.period : 16'(TIMEOUT_TICKS);
                    heading[w] = drive_t'(r.dir);
                    tick_cnt[w] = '0;
                    edges_to_go = IDLE_EDGES;
                    drive[w] = drive_t'(r.dir);
                end
                FN_MOVE:
                    start_counted(r.travel, 1'b0);
                FN_TURN:
                    start_counted(r.travel, 1'b1);
                default:
                    stop_motion();
            endcase
            s.left_drv = drive[0];
            s.right_drv = drive[1];
            s.busy = (edges_to_go != IDLE_EDGES);
            s.left_per = avg_per[0];
            s.right_per = avg_per[1];
            expected_status.push_back(s);
        endfunction

        function void report(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(wheel_status_t got);
            wheel_status_t want;
            if (expected_status.size() == 0)
            begin
                report("result arrived with no request waiting");
                return;
            end
            want = expected_status.pop_front();
            if (got.left_drv !== want.left_drv || got.right_drv !== want.right_drv ||
                got.busy !== want.busy || got.left_per !== want.left_per ||
                got.right_per !== want.right_per)
                report($sformatf({"mismatch: expected drive %0d/%0d busy %0d period %0d/%0d,",
                                  " got drive %0d/%0d busy %0d period %0d/%0d"},
                                 want.left_drv, want.right_drv, want.busy, want.left_per,
                                 want.right_per, got.left_drv, got.right_drv, got.busy,
                                 got.left_per, got.right_per));
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void check_leftovers();
            if (expected_status.size() != 0)
                report($sformatf("%0d results never arrived", expected_status.size()));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_ready;
    logic [2:0]         func;
    logic               sensor_high;
    logic               wheel_sel;
    logic [15:0]        walk_period;
    logic [1:0]         walk_dir;
    logic signed [15:0] travel;
    logic               res_valid;
    logic               res_ready;
    logic [1:0]         left_drive;
    logic [1:0]         right_drive;
    logic               busy_res;
    logic [14:0]        left_period;
    logic [14:0]        right_period;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    wheel_state_tracker tracker = new();
    int                 cycle_count = 0;
    int                 cmd_idle_pct = 0;
    int                 res_stall_pct = 0;
    int                 hold_left = HOLD_CYCLES;
    logic               hold_req = 1'b0;

    two_wheel_bang_bang_speed_control u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .func        (func),
        .sensor_high (sensor_high),
        .wheel_sel   (wheel_sel),
        .walk_period (walk_period),
        .walk_dir    (walk_dir),
        .travel      (travel),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .busy_res    (busy_res),
        .left_period (left_period),
        .right_period(right_period),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** two_wheel_bang_bang_speed_control: FAILED **");
            $finish;
        end
    end

    // The long hold-off runs once, after the main process raises hold_req.
    always @(negedge clk)
    begin
        if (hold_req && hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            res_ready <= ($urandom_range(99) >= res_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        wheel_status_t got;
        if (rst_n && res_valid && res_ready)
        begin
            got.left_drv = drive_t'(left_drive);
            got.right_drv = drive_t'(right_drive);
            got.busy = busy_res;
            got.left_per = left_period;
            got.right_per = right_period;
            tracker.check_result(got);
        end
    end

    task automatic send_request(input wheel_request_t r);
        while ($urandom_range(99) < cmd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        func <= r.fn;
        sensor_high <= r.sensor;
        wheel_sel <= r.wheel;
        walk_period <= r.period;
        walk_dir <= r.dir;
        travel <= r.travel;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        tracker.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_fields(input func_t fn, input logic sensor, input logic wheel,
                               input logic [15:0] period, input drive_t dir,
                               input logic signed [15:0] edge_count);
        wheel_request_t r;
        r.fn = fn;
        r.sensor = sensor;
        r.wheel = wheel;
        r.period = period;
        r.dir = dir;
        r.travel = edge_count;
        send_request(r);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic write_config(input logic [15:0] fast, input logic [15:0] slow,
                                input logic [15:0] limit);
        write_reg(CFG_FAST, fast);
        write_reg(CFG_SLOW, slow);
        write_reg(CFG_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic func_t pick_func();
        int n;
        n = $urandom_range(99);
        if (n < 33)
            return FN_TICK;
        else if (n < 45)
            return FN_LEDGE;
        else if (n < 60)
            return FN_REDGE;
        else if (n < 74)
            return FN_CTRL;
        else if (n < 83)
            return FN_WALK;
        else if (n < 90)
            return FN_MOVE;
        else if (n < 97)
            return FN_TURN;
        return FN_RESET;
    endfunction

    function automatic wheel_request_t random_request(input func_t fn);
        wheel_request_t     r;
        logic signed [15:0] mag;
        r.fn = fn;
        r.sensor = ($urandom_range(9) < 8);
        r.wheel = 1'($urandom_range(1));
        r.dir = 2'($urandom_range(3));
        case ($urandom_range(3)) inside
            0, 1: r.period = 16'($urandom_range(300));
            2: r.period = 16'($urandom);
            default:
                case ($urandom_range(3))
                    0: r.period = 16'(TIMEOUT_TICKS);
                    1: r.period = 16'(TIMEOUT_TICKS - 1);
                    2: r.period = 16'hFFFF;
                    default: r.period = 16'h0000;
                endcase
        endcase
        case ($urandom_range(9))
            7: mag = 16'($urandom_range(13, 60));
            8: mag = 16'($urandom);
            9: mag = 16'sh0000;
            default: mag = 16'($urandom_range(1, 12));
        endcase
        r.travel = $urandom_range(1) ? -mag : mag;
        if ($urandom_range(19) == 0)
            r.travel = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
        return r;
    endfunction

    task automatic run_random(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(49) == 0)
            begin
                burst = $urandom_range(20, 120);
                repeat (burst) send_request(random_request(FN_TICK));
                sent += burst;
            end
            else
            begin
                send_request(random_request(pick_func()));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        func = FN_TICK;
        sensor_high = 1'b0;
        wheel_sel = 1'b0;
        walk_period = '0;
        walk_dir = DRV_STOP;
        travel = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FAST;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_fields(FN_CTRL, 1'b1, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_TICK, 1'b0, 1'b1, 16'hFFFF, DRV_BRAKE, -16'sd1);
        send_fields(FN_WALK, 1'b0, 1'b0, 16'hFFFF, DRV_FWD, 16'sh0000);
        send_fields(FN_WALK, 1'b1, 1'b1, 16'h0000, DRV_REV, 16'sh7FFF);
        send_fields(FN_TICK, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_TICK, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_TICK, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_LEDGE, 1'b1, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_REDGE, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_REDGE, 1'b1, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_CTRL, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_WALK, 1'b0, 1'b0, 16'd50, DRV_STOP, 16'sh0000);
        send_fields(FN_WALK, 1'b0, 1'b1, 16'd50, DRV_BRAKE, 16'sh0000);
        send_fields(FN_MOVE, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sd2);
        send_fields(FN_REDGE, 1'b1, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_REDGE, 1'b1, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_TURN, 1'b0, 1'b0, 16'h0000, DRV_STOP, -16'sd3);
        send_fields(FN_CTRL, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_MOVE, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh8000);
        send_fields(FN_TURN, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh7FFF);
        send_fields(FN_MOVE, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_TURN, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_RESET, 1'b1, 1'b1, 16'hFFFF, DRV_BRAKE, -16'sd1);
        send_fields(FN_MOVE, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sd30);
        send_fields(FN_TICK, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_LEDGE, 1'b1, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_CTRL, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_LEDGE, 1'b1, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_CTRL, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);
        send_fields(FN_MOVE, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sd7);
        send_fields(FN_TICK, 1'b0, 1'b0, 16'h0000, DRV_STOP, 16'sh0000);

        hold_req <= 1'b1;
        repeat (30) send_request(random_request(pick_func()));
        run_random(250);
        drain();

        write_config(16'd0, 16'(TIMEOUT_TICKS), 16'd0);
        cmd_idle_pct = 74;
        run_random(270);
        drain();

        write_config(16'(TIMEOUT_TICKS), 16'd0, 16'hFFFF);
        cmd_idle_pct = 0;
        res_stall_pct <= 74;
        run_random(270);
        drain();

        write_config(16'($urandom_range(250)), 16'($urandom_range(250)),
                     16'($urandom_range(40)));
        cmd_idle_pct = 20;
        res_stall_pct <= 20;
        run_random(270);
        drain();

        repeat (8) @(posedge clk);
        tracker.check_leftovers();
        if (tracker.fail_count == 0)
            $display("** two_wheel_bang_bang_speed_control: PASSED **");
        else
            $display("** two_wheel_bang_bang_speed_control: FAILED **");
        $finish;
    end

endmodule
